[rtl/core/complex_arithmetic_unit_defines.svh]
// Assertion macros for the complex arithmetic unit.
// Stand-alone header; taken in by the modules that carry checks.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cau assertion failed");
`define CAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cau assertion failed");
`else
`define CAU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CAU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/cau_pkg.sv]
// Shared types for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cau_op_t;

    typedef struct packed {
        logic is_div;
        logic dz;
    } cau_ctrl_t;

endpackage

[rtl/core/cau_div_pipe.sv]
// Restoring divider, one quotient bit per pipeline stage, both lanes in step.
// Depends on cau_pkg.
module cau_div_pipe
    import cau_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16,
    localparam int RW = 3 * W + F + 1,
    localparam int QW = 2 * W + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  cau_ctrl_t     in_ctrl,
    input  logic [1:0]    in_neg,
    input  logic [1:0]    in_ovf,
    input  logic [RW-1:0] in_rem_re,
    input  logic [RW-1:0] in_rem_im,
    input  logic [QW-1:0] in_d,
    output logic          out_valid,
    output cau_ctrl_t     out_ctrl,
    output logic [1:0]    out_neg,
    output logic [1:0]    out_ovf,
    output logic [RW-1:0] out_rem_re,
    output logic [RW-1:0] out_rem_im,
    output logic [W-1:0]  out_q_re,
    output logic [W-1:0]  out_q_im
);

    logic          v_reg    [0:W];
    cau_ctrl_t     ctrl_reg [0:W];
    logic [1:0]    neg_reg  [0:W];
    logic [1:0]    ovf_reg  [0:W];
    logic [RW-1:0] rre_reg  [0:W];
    logic [RW-1:0] rim_reg  [0:W];
    logic [W-1:0]  qre_reg  [0:W];
    logic [W-1:0]  qim_reg  [0:W];
    logic [QW-1:0] d_reg    [0:W];

    assign v_reg[0]    = in_valid;
    assign ctrl_reg[0] = in_ctrl;
    assign neg_reg[0]  = in_neg;
    assign ovf_reg[0]  = in_ovf;
    assign rre_reg[0]  = in_rem_re;
    assign rim_reg[0]  = in_rem_im;
    assign qre_reg[0]  = '0;
    assign qim_reg[0]  = '0;
    assign d_reg[0]    = in_d;

    for (genvar k = 0; k < W; k++) begin : g_stage
        localparam int BIT = W - 1 - k;
        logic [RW-1:0] dsh;
        logic          ge_re;
        logic          ge_im;
        logic [RW-1:0] rre_next;
        logic [RW-1:0] rim_next;
        logic [W-1:0]  qre_next;
        logic [W-1:0]  qim_next;

        always_comb begin
            dsh      = RW'(d_reg[k]) << BIT;
            ge_re    = ctrl_reg[k].is_div && (rre_reg[k] >= dsh);
            ge_im    = ctrl_reg[k].is_div && (rim_reg[k] >= dsh);
            rre_next = ge_re ? rre_reg[k] - dsh : rre_reg[k];
            rim_next = ge_im ? rim_reg[k] - dsh : rim_reg[k];
            qre_next = qre_reg[k];
            qim_next = qim_reg[k];
            qre_next[BIT] = ge_re;
            qim_next[BIT] = ge_im;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctrl_reg[k+1] <= ctrl_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                rre_reg[k+1]  <= rre_next;
                rim_reg[k+1]  <= rim_next;
                qre_reg[k+1]  <= qre_next;
                qim_reg[k+1]  <= qim_next;
                d_reg[k+1]    <= d_reg[k];
            end
        end
    end

    assign out_valid  = v_reg[W];
    assign out_ctrl   = ctrl_reg[W];
    assign out_neg    = neg_reg[W];
    assign out_ovf    = ovf_reg[W];
    assign out_rem_re = rre_reg[W];
    assign out_rem_im = rim_reg[W];
    assign out_q_re   = qre_reg[W];
    assign out_q_im   = qim_reg[W];

endmodule

[rtl/core/complex_arithmetic_unit.sv]
// Complex add/sub/mul/div in signed fixed point, fully pipelined.
// Four front stages, one per quotient bit in cau_div_pipe, one output register.
// Throughput one transfer per cycle; the pipeline holds as a whole while the
// output waits. aresetn (synchronous) clears valid bits only.
// Depends on cau_pkg, cau_div_pipe.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int IDW = ((4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [IDW-1:0] s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]     s_tuser,  // action
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [ODW-1:0] m_tdata,  // res_re, res_im
    output logic [1:0]     m_tuser   // div_zero, overflowed
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int QW = 2 * W + 1;
    localparam int RW = 3 * W + F + 1;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: operands
    logic                s1_valid_reg;
    cau_op_t             s1_op_reg;
    logic signed [W-1:0] a_re_reg, a_im_reg, b_re_reg, b_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg <= cau_op_t'(s_tuser);
            a_re_reg  <= s_tdata[W-1:0];
            a_im_reg  <= s_tdata[2*W-1:W];
            b_re_reg  <= s_tdata[3*W-1:2*W];
            b_im_reg  <= s_tdata[4*W-1:3*W];
        end
    end

    // stage 2: products, sums
    logic                 s2_valid_reg;
    cau_op_t              s2_op_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [W:0]    s_re_reg, s_im_reg;
    logic signed [W:0]    s_re_next, s_im_next;

    always_comb begin
        if (s1_op_reg == OP_SUB) begin
            s_re_next = (W+1)'(a_re_reg) - (W+1)'(b_re_reg);
            s_im_next = (W+1)'(a_im_reg) - (W+1)'(b_im_reg);
        end else begin
            s_re_next = (W+1)'(a_re_reg) + (W+1)'(b_re_reg);
            s_im_next = (W+1)'(a_im_reg) + (W+1)'(b_im_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_op_reg <= s1_op_reg;
            p_rr_reg  <= PW'(a_re_reg) * PW'(b_re_reg);
            p_ii_reg  <= PW'(a_im_reg) * PW'(b_im_reg);
            p_ri_reg  <= PW'(a_re_reg) * PW'(b_im_reg);
            p_ir_reg  <= PW'(a_im_reg) * PW'(b_re_reg);
            p_bb_reg  <= PW'(b_re_reg) * PW'(b_re_reg);
            p_cc_reg  <= PW'(b_im_reg) * PW'(b_im_reg);
            s_re_reg  <= s_re_next;
            s_im_reg  <= s_im_next;
        end
    end

    // stage 3: product sums, divisor
    logic                 s3_valid_reg;
    cau_op_t              s3_op_reg;
    logic signed [QW-1:0] pr_reg, pi_reg, pr_next, pi_next;
    logic [QW-1:0]        d_reg, d_next;
    logic signed [W:0]    s3_re_reg, s3_im_reg;

    always_comb begin
        d_next = QW'($unsigned(p_bb_reg)) + QW'($unsigned(p_cc_reg));
        if (s2_op_reg == OP_DIV) begin
            pr_next = QW'(p_rr_reg) + QW'(p_ii_reg);
            pi_next = QW'(p_ir_reg) - QW'(p_ri_reg);
        end else begin
            pr_next = QW'(p_rr_reg) - QW'(p_ii_reg);
            pi_next = QW'(p_ri_reg) + QW'(p_ir_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_op_reg <= s2_op_reg;
            pr_reg    <= pr_next;
            pi_reg    <= pi_next;
            d_reg     <= d_next;
            s3_re_reg <= s_re_reg;
            s3_im_reg <= s_im_reg;
        end
    end

    // stage 4: sign/magnitude, divider set-up
    logic          s4_valid_reg;
    cau_ctrl_t     s4_ctrl_reg, s4_ctrl_next;
    logic [1:0]    s4_neg_reg, s4_neg_next;
    logic [1:0]    s4_ovf_reg, s4_ovf_next;
    logic [RW-1:0] s4_rre_reg, s4_rim_reg, s4_rre_next, s4_rim_next;
    logic [QW-1:0] s4_d_reg;
    logic [QW-1:0] mr, mi;
    logic [W:0]    sr, si;
    logic [RW-1:0] dlim;

    always_comb begin
        mr   = pr_reg[QW-1] ? QW'(-pr_reg) : QW'(pr_reg);
        mi   = pi_reg[QW-1] ? QW'(-pi_reg) : QW'(pi_reg);
        sr   = s3_re_reg[W] ? (W+1)'(-s3_re_reg) : (W+1)'(s3_re_reg);
        si   = s3_im_reg[W] ? (W+1)'(-s3_im_reg) : (W+1)'(s3_im_reg);
        dlim = RW'(d_reg) << W;
        s4_ctrl_next.is_div = (s3_op_reg == OP_DIV);
        s4_ctrl_next.dz     = (s3_op_reg == OP_DIV) && (d_reg == '0);
        s4_ovf_next = 2'b00;
        case (s3_op_reg)
            OP_MUL: begin
                s4_neg_next = {pi_reg[QW-1], pr_reg[QW-1]};
                s4_rre_next = RW'(mr >> F);
                s4_rim_next = RW'(mi >> F);
            end
            OP_DIV: begin
                s4_neg_next = {pi_reg[QW-1], pr_reg[QW-1]};
                s4_rre_next = RW'(mr) << F;
                s4_rim_next = RW'(mi) << F;
                s4_ovf_next = {s4_rim_next >= dlim, s4_rre_next >= dlim};
            end
            default: begin
                s4_neg_next = {s3_im_reg[W], s3_re_reg[W]};
                s4_rre_next = RW'(sr);
                s4_rim_next = RW'(si);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_ctrl_reg <= s4_ctrl_next;
            s4_neg_reg  <= s4_neg_next;
            s4_ovf_reg  <= s4_ovf_next;
            s4_rre_reg  <= s4_rre_next;
            s4_rim_reg  <= s4_rim_next;
            s4_d_reg    <= d_reg;
        end
    end

    // quotient stages
    logic          dv_valid;
    cau_ctrl_t     dv_ctrl;
    logic [1:0]    dv_neg, dv_ovf;
    logic [RW-1:0] dv_rre, dv_rim;
    logic [W-1:0]  dv_qre, dv_qim;

    cau_div_pipe #(.W(W), .F(F)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s4_valid_reg),
        .in_ctrl    (s4_ctrl_reg),
        .in_neg     (s4_neg_reg),
        .in_ovf     (s4_ovf_reg),
        .in_rem_re  (s4_rre_reg),
        .in_rem_im  (s4_rim_reg),
        .in_d       (s4_d_reg),
        .out_valid  (dv_valid),
        .out_ctrl   (dv_ctrl),
        .out_neg    (dv_neg),
        .out_ovf    (dv_ovf),
        .out_rem_re (dv_rre),
        .out_rem_im (dv_rim),
        .out_q_re   (dv_qre),
        .out_q_im   (dv_qim)
    );

    // output: saturate and narrow, zero on divide by zero
    logic          m_tvalid_reg;
    logic [W-1:0]  res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic          dz_reg, ovf_reg, ovf_next;
    logic [RW-1:0] mag_re, mag_im, lim_re, lim_im;
    logic          big_re, big_im;

    always_comb begin
        mag_re = dv_ctrl.is_div ? RW'(dv_qre) : dv_rre;
        mag_im = dv_ctrl.is_div ? RW'(dv_qim) : dv_rim;
        lim_re = (RW'(1) << (W - 1)) - RW'(!dv_neg[0]);
        lim_im = (RW'(1) << (W - 1)) - RW'(!dv_neg[1]);
        big_re = (dv_ctrl.is_div && dv_ovf[0]) || (mag_re > lim_re);
        big_im = (dv_ctrl.is_div && dv_ovf[1]) || (mag_im > lim_im);
        if (big_re) begin
            res_re_next = W'(lim_re);
        end else begin
            res_re_next = dv_neg[0] ? W'(-mag_re) : W'(mag_re);
        end
        if (big_im) begin
            res_im_next = W'(lim_im);
        end else begin
            res_im_next = dv_neg[1] ? W'(-mag_im) : W'(mag_im);
        end
        ovf_next = big_re || big_im;
        if (dv_ctrl.dz) begin
            res_re_next = '0;
            res_im_next = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            dz_reg     <= dv_ctrl.dz;
            ovf_reg    <= ovf_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ODW'({res_im_reg, res_re_reg});
    assign m_tuser  = {ovf_reg, dz_reg};

    `CAU_ASSERT_IMP(a_dz_zero, aclk, aresetn, m_tvalid_reg && dz_reg, res_re_reg == '0 && res_im_reg == '0 && !ovf_reg)
    `CAU_ASSERT_IMP(a_ovf_sat, aclk, aresetn, m_tvalid_reg && ovf_reg, res_re_reg == {1'b1, {(W-1){1'b0}}} || res_re_reg == {1'b0, {(W-1){1'b1}}} || res_im_reg == {1'b1, {(W-1){1'b0}}} || res_im_reg == {1'b0, {(W-1){1'b1}}})
    `CAU_ASSERT_NXT(a_hold, aclk, aresetn, !en, $stable(dv_valid) && $stable(s4_valid_reg))

endmodule

[sim/complex_arithmetic_unit_test.sv]
// Self-checking bench for complex_arithmetic_unit: directed table, then random transfers,
// each result compared against a table value or a behavioural complex fixed-point predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 100ps

module complex_arithmetic_unit_test;
    import cau_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        ovf;
    } cplx_res_t;

    typedef struct {
        cau_op_t     op;
        logic [31:0] ar, ai, br, bi;
        logic        known;
        cplx_res_t   res;
    } stim_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [127:0]   s_tdata = '0;
    logic [1:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [63:0]    m_tdata;
    logic [1:0]     m_tuser;

    cplx_res_t pending_results[$];
    int        errors = 0;
    bit        calm = 1'b0;

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [31:0] saturate(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'(QMAX)) begin
            ovf = 1'b1;
            return QMAX;
        end
        if (v < 128'(QMIN)) begin
            ovf = 1'b1;
            return QMIN;
        end
        return v[31:0];
    endfunction

    // signed division in SV truncates toward zero; >> on magnitudes likewise
    function automatic logic signed [127:0] trunc_shr(input logic signed [127:0] v);
        logic signed [127:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    function automatic cplx_res_t complex_result(input cau_op_t op,
            input logic [31:0] ar, ai, br, bi);
        cplx_res_t r;
        logic signed [127:0] xr, xi, yr, yi, sr, si, den;
        logic ovf;
        xr = 128'(signed'(ar));
        xi = 128'(signed'(ai));
        yr = 128'(signed'(br));
        yi = 128'(signed'(bi));
        ovf = 1'b0;
        r.dz = 1'b0;
        case (op)
            OP_ADD: begin
                sr = xr + yr;
                si = xi + yi;
            end
            OP_SUB: begin
                sr = xr - yr;
                si = xi - yi;
            end
            OP_MUL: begin
                sr = trunc_shr(xr * yr - xi * yi);
                si = trunc_shr(xr * yi + xi * yr);
            end
            default: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.dz = 1'b1;
                    sr = 0;
                    si = 0;
                end else begin
                    sr = ((xr * yr + xi * yi) * (128'sd1 <<< FB)) / den;
                    si = ((xi * yr - xr * yi) * (128'sd1 <<< FB)) / den;
                end
            end
        endcase
        r.re = saturate(sr, ovf);
        r.im = saturate(si, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 5))
            0: return QMAX;
            1: return QMIN;
            2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< FB;
            3: return 32'($urandom_range(0, 16'hffff)) - 32'h8000;
            4: return 0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input cau_op_t op, input logic [31:0] ar, ai, br, bi);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {bi, br, ai, ar};
        pending_results.push_back(complex_result(op, ar, ai, br, bi));
        do @(posedge aclk); while (!s_tready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                cplx_res_t e;
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.re) begin
                    $error("res_re expected %h actual %h", e.re, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.im) begin
                    $error("res_im expected %h actual %h", e.im, m_tdata[63:32]);
                    errors++;
                end
                if (m_tuser[0] !== e.dz) begin
                    $error("div_zero expected %b actual %b", e.dz, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.ovf) begin
                    $error("overflowed expected %b actual %b", e.ovf, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    initial begin
        stim_row_t table_rows[$];
        stim_row_t row;
        cau_op_t op;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // known rows: plain sums and products, saturation, divide by zero; the rest use the predictor
        table_rows.push_back('{OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
            32'h0004_0000, 1'b1, '{32'h0004_0000, 32'h0006_0000, 1'b0, 1'b0}});
        table_rows.push_back('{OP_ADD, QMAX, QMIN, 32'h1, 32'hffffffff, 1'b1,
            '{QMAX, QMIN, 1'b0, 1'b1}});
        table_rows.push_back('{OP_SUB, QMIN, QMAX, 32'h1, 32'hffffffff, 1'b1,
            '{QMIN, QMAX, 1'b0, 1'b1}});
        table_rows.push_back('{OP_DIV, QMAX, QMIN, 32'h0, 32'h0, 1'b1,
            '{32'h0, 32'h0, 1'b1, 1'b0}});
        table_rows.push_back('{OP_MUL, 32'h0002_0000, 32'h0, 32'h0003_0000, 32'h0, 1'b1,
            '{32'h0006_0000, 32'h0, 1'b0, 1'b0}});
        table_rows.push_back('{OP_MUL, QMIN, QMIN, QMIN, QMIN, 1'b0, '{0, 0, 0, 0}});
        table_rows.push_back('{OP_MUL, QMAX, QMAX, QMAX, QMIN, 1'b0, '{0, 0, 0, 0}});
        table_rows.push_back('{OP_MUL, 32'hffff_ffff, 32'h0, 32'h1, 32'h0, 1'b0,
            '{0, 0, 0, 0}});
        table_rows.push_back('{OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 1'b0,
            '{0, 0, 0, 0}});
        table_rows.push_back('{OP_DIV, QMAX, QMAX, 32'h1, 32'h0, 1'b0, '{0, 0, 0, 0}});
        table_rows.push_back('{OP_DIV, QMIN, QMAX, QMIN, QMIN, 1'b0, '{0, 0, 0, 0}});
        table_rows.push_back('{OP_DIV, 32'hffff_0000, 32'h1, 32'h0, 32'hffffffff, 1'b0,
            '{0, 0, 0, 0}});
        table_rows.push_back('{OP_SUB, 32'h0, 32'h0, QMIN, QMIN, 1'b0, '{0, 0, 0, 0}});
        table_rows.push_back('{OP_ADD, QMIN, QMIN, QMIN, QMIN, 1'b0, '{0, 0, 0, 0}});

        foreach (table_rows[i]) begin
            row = table_rows[i];
            send(row.op, row.ar, row.ai, row.br, row.bi);
            if (row.known) pending_results[$] = row.res;
        end

        for (int i = 0; i < 400; i++) begin
            if (i == 340) calm = 1'b1;
            op = cau_op_t'($urandom_range(0, 3));
            if (op == OP_DIV && $urandom_range(0, 9) == 0)
                send(op, rand_part(), rand_part(), 32'h0, 32'h0);
            else
                send(op, rand_part(), rand_part(), rand_part(), rand_part());
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[complex_arithmetic_unit.f]
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_div_pipe.sv
rtl/core/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_test.sv
